@@ rtl/sssg_pkg.sv @@
// ----------------------------------------------------------------------------
// Segmented sine sample generator package
// Register map constants and the quarter-wave sine table builder.
// ----------------------------------------------------------------------------
package sssg_pkg;

   // Configuration port geometry: byte addresses, one word per register.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Register indexes (word address taken from csr_paddr[2]).
   localparam logic REG_ZERO_LEVEL = 1'b0;

   localparam logic [7:0]  ZERO_LEVEL_RESET = 8'd128;
   localparam logic [63:0] PI_Q40           = 64'h0000_0324_3F6A_8885;
   localparam logic [15:0] SINE_ONE         = 16'd32768;

   // Term n of the Taylor series divides by (2n)(2n+1).
   function automatic logic [63:0] taylor_divide(input int n, input logic [63:0] v);
      logic [63:0] q;
      case (n)
         1: q = v / 64'd6;
         2: q = v / 64'd20;
         3: q = v / 64'd42;
         4: q = v / 64'd72;
         5: q = v / 64'd110;
         6: q = v / 64'd156;
         7: q = v / 64'd210;
         8: q = v / 64'd272;
         default: q = v;
      endcase
      return q;
   endfunction

   // Entry k of the quarter-wave table in Q1.15, evaluated at elaboration.
   function automatic logic [15:0] sine_entry(input int unsigned k,
                                              input int unsigned index_bits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        prod;
      logic [63:0]        rnd;
      logic signed [63:0] sum;
      x    = (64'(k) * PI_Q40) >> (index_bits + 11);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 8; n++) begin
         prod = (term * x2) >> 30;
         term = taylor_divide(n, prod);
         if ((n & 1) == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      rnd = ($unsigned(sum) + 64'd16384) >> 15;
      return rnd[15:0];
   endfunction

endpackage

@@ rtl/segmented_sine_sample_generator.sv @@
// ----------------------------------------------------------------------------
// Segmented sine sample generator
// Direct digital synthesis of an 8-bit sine waveform in frequency segments.
// ----------------------------------------------------------------------------
// Each item on the req_ channel (segment_start, phase_step, amplitude)
// produces exactly one item on the rsp_ channel (sample, negative_segment).
// A segment start clears the phase; the new segment is drawn inverted when a
// sample has already been produced and the last sample was not below the zero
// level. The phase then advances by phase_step each item.
//
// The block is a three-stage pipeline: phase register, registered sine table
// read, and the result register holding the scaled, rounded and saturated
// sample. A result passes through these three registers in that order; one
// item is accepted every cycle while req_stall is low. The sign of each segment
// is decided in the last stage from the sample just before it, so back-to-back
// items follow.
//
// When the receiver stalls, the result register holds; earlier stages keep
// filling until the pipeline is full, then req_stall rises. Reset empties the
// pipeline, clears the phase and segment state, and sets zero_level to 128. The user
// writes the zero_level register over the csr_ port only while the block idles; the block does not enforce this.
// ----------------------------------------------------------------------------
module segmented_sine_sample_generator #(
   parameter int SINE_INDEX_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_segment_start,
   input  logic [31:0]                         req_phase_step,
   input  logic [14:0]                         req_amplitude,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_sample,
   output logic                                rsp_negative_segment,
   // Configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sssg_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [sssg_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [sssg_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import sssg_pkg::*;

   localparam int TABLE_SIZE = 1 << SINE_INDEX_BITS;

   // Sine table: constant contents, read through a data register.
   logic [15:0] sine_rom [TABLE_SIZE];
   for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_rom
      assign sine_rom[k] = sine_entry(k, SINE_INDEX_BITS);
   end

   // Configuration
   logic [7:0] zero_level_ff;
   logic       csr_write;

   // Phase state
   logic [31:0] phase_acc_ff, phase_acc_in;
   logic [31:0] item_phase;

   // Stage 1: phase
   logic                       s1_valid_ff;
   logic                       s1_start_ff;
   logic [14:0]                s1_amp_ff;
   logic [1:0]                 s1_quad_ff;
   logic [SINE_INDEX_BITS-1:0] s1_index_ff;

   // Stage 2: table data
   logic        s2_valid_ff;
   logic        s2_start_ff;
   logic [14:0] s2_amp_ff;
   logic        s2_qneg_ff;
   logic        s2_one_ff;
   logic [15:0] s2_rom_ff;

   // Stage 3: result and segment state
   logic       s3_valid_ff;
   logic [7:0] sample_ff, sample_in;
   logic       inverted_ff, inverted_in;
   logic       seen_ff;

   logic req_accept;
   logic s1_free, s2_free, s3_free;
   logic s2_load, s3_load;

   logic [SINE_INDEX_BITS-1:0] rom_addr;

   logic [15:0]        mag;
   logic [30:0]        prod;
   logic [30:0]        base;
   logic               negate;
   logic signed [32:0] val;
   logic signed [32:0] rnd;

   // ---------------------------------------------------------------- control
   assign s3_free    = !s3_valid_ff || !rsp_stall;
   assign s2_free    = !s2_valid_ff || s3_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_stall  = !s1_free;
   assign req_accept = req_valid && !req_stall;
   assign s2_load    = s1_valid_ff && s2_free;
   assign s3_load    = s2_valid_ff && s3_free;

   // ---------------------------------------------------------------- config
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_ZERO_LEVEL)
                       ? {{(CSR_DATA_BITS-8){1'b0}}, zero_level_ff}
                       : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_level_ff <= ZERO_LEVEL_RESET;
      end else if (csr_write && csr_paddr[2] == REG_ZERO_LEVEL) begin
         zero_level_ff <= csr_pwdata[7:0];
      end
   end

   // ---------------------------------------------------------------- stage 1
   assign item_phase   = req_segment_start ? 32'd0 : phase_acc_ff;
   assign phase_acc_in = item_phase + req_phase_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_acc_ff <= phase_acc_in;
         end
         if (s1_free) begin
            s1_valid_ff <= req_accept;
         end
      end
      if (req_accept) begin
         s1_start_ff <= req_segment_start;
         s1_amp_ff   <= req_amplitude;
         s1_quad_ff  <= item_phase[31:30];
         s1_index_ff <= item_phase[29 -: SINE_INDEX_BITS];
      end
   end

   // ---------------------------------------------------------------- stage 2
   // Odd quadrants run the table backwards; their index zero is the peak.
   assign rom_addr = s1_quad_ff[0] ? ('0 - s1_index_ff) : s1_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_load) begin
         s2_start_ff <= s1_start_ff;
         s2_amp_ff   <= s1_amp_ff;
         s2_qneg_ff  <= s1_quad_ff[1];
         s2_one_ff   <= s1_quad_ff[0] && (s1_index_ff == '0);
         s2_rom_ff   <= sine_rom[rom_addr];
      end
   end

   // ---------------------------------------------------------------- stage 3
   // The sign of a new segment looks at the sample of the item just before it.
   always_comb begin
      if (s2_start_ff) begin
         inverted_in = seen_ff && (sample_ff >= zero_level_ff);
      end else begin
         inverted_in = inverted_ff;
      end
   end

   assign mag    = s2_one_ff ? SINE_ONE : s2_rom_ff;
   assign prod   = 31'(s2_amp_ff * mag);
   assign base   = {zero_level_ff, 23'd0};
   assign negate = s2_qneg_ff ^ inverted_in;
   assign val    = negate ? $signed({2'b00, base}) - $signed({2'b00, prod})
                          : $signed({2'b00, base}) + $signed({2'b00, prod});
   assign rnd    = val + 33'sd4194304;

   // A negative value rounds to zero or below and clamps to zero.
   always_comb begin
      if (val[32]) begin
         sample_in = 8'd0;
      end else if (rnd[31:23] > 9'd255) begin
         sample_in = 8'd255;
      end else begin
         sample_in = rnd[30:23];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         sample_ff   <= '0;
         inverted_ff <= 1'b0;
         seen_ff     <= 1'b0;
      end else begin
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s3_load) begin
            sample_ff   <= sample_in;
            inverted_ff <= inverted_in;
            seen_ff     <= 1'b1;
         end
      end
   end

   assign rsp_valid            = s3_valid_ff;
   assign rsp_sample           = sample_ff;
   assign rsp_negative_segment = inverted_ff;

   // ---------------------------------------------------------------- checks
   a_start_clears_phase: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_segment_start) |=> (s1_quad_ff == 2'd0 && s1_index_ff == '0))
      else $error("segment start did not clear the phase");

   a_first_segment_positive: assert property (@(posedge clock) disable iff (reset)
      (s3_load && s2_start_ff && !seen_ff) |=> !inverted_ff)
      else $error("first segment drawn inverted");

   a_sign_held_in_segment: assert property (@(posedge clock) disable iff (reset)
      (s3_load && !s2_start_ff) |=> (inverted_ff == $past(inverted_ff)))
      else $error("segment sign changed without a segment start");

   a_stage2_held_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s3_free) |=> (s2_valid_ff && $stable(s2_rom_ff)))
      else $error("table stage overwritten while the result was stalled");

endmodule
